// ===== rtl/core/ejd_pkg.sv =====
// ----------------------------------------------------------------------------
// ejd_pkg
// Shared types, constants and the doubling program of the Jacobian point
// doubler.
// ----------------------------------------------------------------------------
package ejd_pkg;

  localparam int LIMB_W         = 64;
  localparam int LIMBS          = 3;
  localparam int COORD_W        = LIMB_W * LIMBS;
  localparam int FIELD_BITS_DEF = 192;
  localparam int CFG_IDX_W      = 2;
  localparam int RF_AW          = 4;
  localparam int RF_DEPTH       = 1 << RF_AW;
  localparam int PROG_LEN       = 25;
  localparam int PC_W           = $clog2(PROG_LEN);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_MID  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_HIGH = CFG_IDX_W'(2);

  localparam logic [LIMB_W-1:0] MOD_LOW_RST  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [LIMB_W-1:0] MOD_MID_RST  = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [LIMB_W-1:0] MOD_HIGH_RST = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_RED,
    OP_MUL
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FETCH,
    ST_EXEC,
    ST_WAIT,
    ST_RDA,
    ST_RDB,
    ST_OUT,
    ST_ZERO
  } seq_state_t;

  typedef logic [RF_AW-1:0] rf_addr_t;

  // register file slots
  localparam rf_addr_t R_X  = RF_AW'(0);
  localparam rf_addr_t R_Y  = RF_AW'(1);
  localparam rf_addr_t R_Z  = RF_AW'(2);
  localparam rf_addr_t R_ZZ = RF_AW'(3);
  localparam rf_addr_t R_A  = RF_AW'(4);
  localparam rf_addr_t R_B  = RF_AW'(5);
  localparam rf_addr_t R_T  = RF_AW'(6);
  localparam rf_addr_t R_U  = RF_AW'(7);
  localparam rf_addr_t R_M  = RF_AW'(8);
  localparam rf_addr_t R_YY = RF_AW'(9);
  localparam rf_addr_t R_S  = RF_AW'(10);
  localparam rf_addr_t R_Q  = RF_AW'(11);
  localparam rf_addr_t R_X3 = RF_AW'(12);
  localparam rf_addr_t R_D  = RF_AW'(13);
  localparam rf_addr_t R_Y3 = RF_AW'(14);
  localparam rf_addr_t R_Z3 = RF_AW'(15);

  typedef struct packed {
    alu_op_t  op;
    rf_addr_t dst;
    rf_addr_t sa;
    rf_addr_t sb;
  } instr_t;

  localparam instr_t PROG [PROG_LEN] = '{
    '{OP_RED, R_X,  R_X,  R_X },
    '{OP_RED, R_Y,  R_Y,  R_Y },
    '{OP_RED, R_Z,  R_Z,  R_Z },
    '{OP_MUL, R_ZZ, R_Z,  R_Z },
    '{OP_SUB, R_A,  R_X,  R_ZZ},
    '{OP_ADD, R_B,  R_X,  R_ZZ},
    '{OP_MUL, R_T,  R_A,  R_B },
    '{OP_ADD, R_U,  R_T,  R_T },
    '{OP_ADD, R_M,  R_U,  R_T },
    '{OP_MUL, R_YY, R_Y,  R_Y },
    '{OP_MUL, R_S,  R_X,  R_YY},
    '{OP_ADD, R_S,  R_S,  R_S },
    '{OP_ADD, R_S,  R_S,  R_S },
    '{OP_MUL, R_Q,  R_M,  R_M },
    '{OP_SUB, R_Q,  R_Q,  R_S },
    '{OP_SUB, R_X3, R_Q,  R_S },
    '{OP_MUL, R_T,  R_YY, R_YY},
    '{OP_ADD, R_T,  R_T,  R_T },
    '{OP_ADD, R_T,  R_T,  R_T },
    '{OP_ADD, R_T,  R_T,  R_T },
    '{OP_SUB, R_D,  R_S,  R_X3},
    '{OP_MUL, R_Q,  R_M,  R_D },
    '{OP_SUB, R_Y3, R_Q,  R_T },
    '{OP_MUL, R_Z3, R_Y,  R_Z },
    '{OP_ADD, R_Z3, R_Z3, R_Z3}
  };

  localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROG_LEN - 1);

endpackage

// ===== rtl/core/ejd_if.sv =====
// ----------------------------------------------------------------------------
// ejd_in_if / ejd_out_if
// Valid/ready channels carrying a Jacobian point as nine 64-bit limbs.
// ----------------------------------------------------------------------------
interface ejd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] x_limb0, x_limb1, x_limb2;
  logic [63:0] y_limb0, y_limb1, y_limb2;
  logic [63:0] z_limb0, z_limb1, z_limb2;

  modport source (output valid, x_limb0, x_limb1, x_limb2, y_limb0, y_limb1, y_limb2,
                  z_limb0, z_limb1, z_limb2, input ready);
  modport sink   (input valid, x_limb0, x_limb1, x_limb2, y_limb0, y_limb1, y_limb2,
                  z_limb0, z_limb1, z_limb2, output ready);
endinterface

interface ejd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] rx_limb0, rx_limb1, rx_limb2;
  logic [63:0] ry_limb0, ry_limb1, ry_limb2;
  logic [63:0] rz_limb0, rz_limb1, rz_limb2;

  modport source (output valid, rx_limb0, rx_limb1, rx_limb2, ry_limb0, ry_limb1, ry_limb2,
                  rz_limb0, rz_limb1, rz_limb2, input ready);
  modport sink   (input valid, rx_limb0, rx_limb1, rx_limb2, ry_limb0, ry_limb1, ry_limb2,
                  rz_limb0, rz_limb1, rz_limb2, output ready);
endinterface

// ===== rtl/core/ejd_modalu.sv =====
// ----------------------------------------------------------------------------
// ejd_modalu
// Modular arithmetic unit: add and subtract, reduction one bit per cycle,
// multiplication by interleaved double-and-add (a doubling and an add step per bit).
// ----------------------------------------------------------------------------
module ejd_modalu #(
  parameter int W = ejd_pkg::FIELD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ejd_pkg::alu_cmd_t   cmd,
  input  logic [W-1:0]        a_i,
  input  logic [W-1:0]        b_i,
  input  logic [W-1:0]        p_i,
  output logic                done_o,
  output logic [W-1:0]        result_o
);
  import ejd_pkg::*;

  localparam int IW = $clog2(W);

  logic          busy_r, done_r, phase_r;
  logic [IW-1:0] cnt_r;
  alu_op_t       op_r;
  logic [W-1:0]  a_r, b_r, r_r;

  logic [W-1:0]  u, v, add_res, sub_res, res;
  logic          cin, last;
  logic [W:0]    sum, dsub;
  logic [W+1:0]  diff;

  always_comb begin
    u   = r_r;
    v   = r_r;
    cin = 1'b0;
    unique case (op_r)
      OP_ADD: begin
        u = a_r;
        v = b_r;
      end
      OP_SUB: ;
      OP_RED: cin = a_r[cnt_r];
      OP_MUL: if (phase_r) v = b_r[cnt_r] ? a_r : '0;
      default: ;
    endcase
    sum     = {1'b0, u} + {1'b0, v} + (W+1)'(cin);
    diff    = {1'b0, sum} - {2'b00, p_i};
    add_res = diff[W+1] ? sum[W-1:0] : diff[W-1:0];
    dsub    = {1'b0, a_r} - {1'b0, b_r};
    sub_res = dsub[W] ? dsub[W-1:0] + p_i : dsub[W-1:0];
    res     = (op_r == OP_SUB) ? sub_res : add_res;
    last    = (op_r == OP_ADD) || (op_r == OP_SUB) ||
              ((op_r == OP_RED) && (cnt_r == '0)) ||
              ((op_r == OP_MUL) && phase_r && (cnt_r == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
      op_r    <= OP_ADD;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r  <= 1'b1;
        op_r    <= cmd.op;
        phase_r <= 1'b0;
        cnt_r   <= IW'(W - 1);
      end else if (busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (op_r == OP_MUL) begin
          phase_r <= ~phase_r;
          if (phase_r) cnt_r <= cnt_r - 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r <= a_i;
      b_r <= b_i;
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= res;
    end
  end

  assign done_o   = done_r;
  assign result_o = r_r;

endmodule

// ===== rtl/core/ecc_jacobian_point_double_top.sv =====
// ----------------------------------------------------------------------------
// ecc_jacobian_point_double_top
// Jacobian point doubling (a = -3) modulo a configurable prime.
// ----------------------------------------------------------------------------
// Each point runs the doubling program on the bit-serial modular unit:
// three reductions, eight multiplications and fourteen add/sub steps,
// each with a register-file read and write-back around it. Intermediates
// live in a 16-entry register-file memory. One request can wait in the
// input buffer and one result in the output register while the next point
// is worked on. A zero modulus gives an all-zero result without running
// the program.
module ecc_jacobian_point_double_top #(
  parameter int FIELD_BITS = ejd_pkg::FIELD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ejd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ejd_pkg::LIMB_W-1:0]       cfg_wdata,
  ejd_in_if.sink                           in_ch,
  ejd_out_if.source                        out_ch
);
  import ejd_pkg::*;

  localparam int W = FIELD_BITS;

  // configuration
  logic [LIMB_W-1:0] mod_low_r, mod_mid_r, mod_high_r;
  logic [W-1:0]      p;
  logic              p_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_low_r  <= MOD_LOW_RST;
      mod_mid_r  <= MOD_MID_RST;
      mod_high_r <= MOD_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MOD_LOW:  mod_low_r  <= cfg_wdata;
        CFG_MOD_MID:  mod_mid_r  <= cfg_wdata;
        CFG_MOD_HIGH: mod_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign p      = W'({mod_high_r, mod_mid_r, mod_low_r});
  assign p_zero = (p == '0);

  // input buffer
  logic         in_full_r;
  logic [W-1:0] in_x_r, in_y_r, in_z_r;
  logic         in_take, in_release;

  assign in_ch.ready = !in_full_r;
  assign in_take     = in_ch.valid && !in_full_r;

  // sequencer
  seq_state_t       state_r, state_nxt;
  logic [PC_W-1:0]  pc_r;
  logic [1:0]       ld_cnt_r;
  instr_t           cur;

  // register file
  logic [W-1:0] mem [RF_DEPTH];
  logic         mem_we;
  rf_addr_t     waddr, raddr_a, raddr_b;
  logic [W-1:0] wdata, rdata_a_r, rdata_b_r;

  // output
  logic         out_valid_r, out_load, out_zero;
  logic [W-1:0] out_x_r, out_y_r, out_z_r, hold_x_r, hold_y_r;

  alu_cmd_t     alu_cmd;
  logic         alu_done;
  logic [W-1:0] alu_res;

  assign cur = PROG[pc_r];

  ejd_modalu #(.W(W)) u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (alu_cmd),
    .a_i      (rdata_a_r),
    .b_i      (rdata_b_r),
    .p_i      (p),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_full_r) state_nxt = p_zero ? ST_ZERO : ST_LOAD;
      ST_LOAD:  if (ld_cnt_r == 2'd2) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_WAIT;
      ST_WAIT:  if (alu_done) state_nxt = (pc_r == PC_LAST) ? ST_RDA : ST_FETCH;
      ST_RDA:   state_nxt = ST_RDB;
      ST_RDB:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r) state_nxt = ST_IDLE;
      ST_ZERO:  if (!out_valid_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we        = 1'b0;
    waddr         = cur.dst;
    wdata         = alu_res;
    raddr_a       = cur.sa;
    raddr_b       = cur.sb;
    alu_cmd.start = 1'b0;
    alu_cmd.op    = cur.op;
    out_load      = 1'b0;
    out_zero      = 1'b0;
    in_release    = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        mem_we     = 1'b1;
        waddr      = RF_AW'(ld_cnt_r);
        wdata      = (ld_cnt_r == 2'd0) ? in_x_r : (ld_cnt_r == 2'd1) ? in_y_r : in_z_r;
        in_release = (ld_cnt_r == 2'd2);
      end
      ST_EXEC:  alu_cmd.start = 1'b1;
      ST_WAIT:  mem_we = alu_done;
      ST_RDA: begin
        raddr_a = R_X3;
        raddr_b = R_Y3;
      end
      ST_RDB, ST_OUT: begin
        raddr_a  = R_Z3;
        out_load = (state_r == ST_OUT) && !out_valid_r;
      end
      ST_ZERO: begin
        out_load   = !out_valid_r;
        out_zero   = 1'b1;
        in_release = !out_valid_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      ld_cnt_r    <= '0;
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_take) in_full_r <= 1'b1;
      else if (in_release) in_full_r <= 1'b0;
      ld_cnt_r <= (state_r == ST_LOAD) ? ld_cnt_r + 2'd1 : 2'd0;
      if (state_r == ST_LOAD) pc_r <= '0;
      else if (state_r == ST_WAIT && alu_done && pc_r != PC_LAST) pc_r <= pc_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_x_r <= W'({in_ch.x_limb2, in_ch.x_limb1, in_ch.x_limb0});
      in_y_r <= W'({in_ch.y_limb2, in_ch.y_limb1, in_ch.y_limb0});
      in_z_r <= W'({in_ch.z_limb2, in_ch.z_limb1, in_ch.z_limb0});
    end
    if (state_r == ST_RDB) begin
      hold_x_r <= rdata_a_r;
      hold_y_r <= rdata_b_r;
    end
    if (out_load) begin
      out_x_r <= out_zero ? '0 : hold_x_r;
      out_y_r <= out_zero ? '0 : hold_y_r;
      out_z_r <= out_zero ? '0 : rdata_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  logic [COORD_W-1:0] rx_full, ry_full, rz_full;
  assign rx_full = COORD_W'(out_x_r);
  assign ry_full = COORD_W'(out_y_r);
  assign rz_full = COORD_W'(out_z_r);

  assign out_ch.valid    = out_valid_r;
  assign out_ch.rx_limb0 = rx_full[LIMB_W-1:0];
  assign out_ch.rx_limb1 = rx_full[2*LIMB_W-1:LIMB_W];
  assign out_ch.rx_limb2 = rx_full[3*LIMB_W-1:2*LIMB_W];
  assign out_ch.ry_limb0 = ry_full[LIMB_W-1:0];
  assign out_ch.ry_limb1 = ry_full[2*LIMB_W-1:LIMB_W];
  assign out_ch.ry_limb2 = ry_full[3*LIMB_W-1:2*LIMB_W];
  assign out_ch.rz_limb0 = rz_full[LIMB_W-1:0];
  assign out_ch.rz_limb1 = rz_full[2*LIMB_W-1:LIMB_W];
  assign out_ch.rz_limb2 = rz_full[3*LIMB_W-1:2*LIMB_W];

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> (state_r == ST_WAIT))
    else $error("modular unit finished outside wait state");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load lost");

  a_load_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> in_full_r)
    else $error("loading point without buffered request");

endmodule
